// ----- rtl/led_color_effect_generator_defines.svh -----
// Assertion macros for the LED color effect generator RTL.
`ifndef LED_COLOR_EFFECT_GENERATOR_DEFINES_SVH
`define LED_COLOR_EFFECT_GENERATOR_DEFINES_SVH

// Checked property, ignored while reset is asserted.
`define LCEG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked property that also holds across reset.
`define LCEG_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/lceg_pkg.sv -----
// Shared types, constants and table functions of the LED color effect generator.
package lceg_pkg;

    localparam int EASE_DEPTH_DEF = 256;
    localparam int TIME_BITS_DEF  = 32;
    localparam int PER_W          = 16;
    localparam int DIV_W          = 17;
    localparam int COLOR_W        = 24;
    localparam int LVL_W          = 8;
    localparam int EASE_W         = 9;
    localparam int MODE_W         = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;
    localparam int STAGE_W        = 3;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    // Effect modes after classification; unknown codes become off.
    typedef enum logic [MODE_W-1:0] {
        MODE_OFF      = 4'd0,
        MODE_SOLID    = 4'd1,
        MODE_BLINK    = 4'd2,
        MODE_FADE_IN  = 4'd3,
        MODE_FADE_OUT = 4'd4,
        MODE_BREATHE  = 4'd5,
        MODE_SHIFT    = 4'd6,
        MODE_RAINBOW  = 4'd7,
        MODE_SIREN    = 4'd8
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EFFECT_MODE = 3'd0,
        REG_COLOR_A     = 3'd1,
        REG_COLOR_B     = 3'd2,
        REG_PERIOD_A    = 3'd3,
        REG_PERIOD_B    = 3'd4
    } reg_idx_t;

    // Current configuration, periods already forced to at least one.
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COLOR_W-1:0] color_a;
        logic [COLOR_W-1:0] color_b;
        logic [PER_W-1:0]   period_a;
        logic [PER_W-1:0]   period_b;
    } cfg_t;

    // Classified item handed from the front to the back.
    typedef struct packed {
        mode_t             mode;
        logic [DIV_W-1:0]  divisor;
    } item_t;

    // Side information that travels with an item through the phase stages.
    typedef struct packed {
        mode_t              mode;
        logic               inv;
        logic               on;
        logic [STAGE_W-1:0] stage;
    } side_t;

    // Rainbow hue for one of the seven stages.
    function automatic logic [COLOR_W-1:0] rainbow_color(input logic [STAGE_W-1:0] stage);
        logic [COLOR_W-1:0] c;
        case (stage)
            3'd0: c = 24'hFF0000;
            3'd1: c = 24'hFF6400;
            3'd2: c = 24'hFFFF00;
            3'd3: c = 24'h00FF00;
            3'd4: c = 24'h00FFFF;
            3'd5: c = 24'h0000FF;
            3'd6: c = 24'hFF00FF;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/lceg_fifo.sv -----
// Two-entry queue that decouples the front from the back.
`include "led_color_effect_generator_defines.svh"

module lceg_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == 2'(DEPTH));
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    `LCEG_ASSERT(a_count_bound, count_reg <= 2'(DEPTH), "queue count beyond depth")
    `LCEG_ASSERT(a_push_fills, do_push && !do_pop |=> !empty, "queue empty after a push")
    `LCEG_ASSERT(a_pop_drains, do_pop && !do_push |=> count_reg == $past(count_reg) - 2'd1,
        "queue count wrong after a pop")
    `LCEG_ASSERT_RST(a_reset_empty, !aresetn |=> empty, "queue not empty after reset")

endmodule

// ----- rtl/lceg_front.sv -----
// Front part: accepts time samples and classifies them by effect mode.
module lceg_front #(
    parameter int TIME_BITS = lceg_pkg::TIME_BITS_DEF
) (
    input  lceg_pkg::cfg_t        cfg,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [31:0]           s_time_ms,
    input  logic                  q_full,
    output logic                  q_push,
    output lceg_pkg::item_t       q_item,
    output logic [TIME_BITS-1:0]  q_time
);
    import lceg_pkg::*;

    logic [DIV_W-1:0] pa_w;
    logic [DIV_W-1:0] pb_w;
    mode_t            mode;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;
    assign q_time  = s_time_ms[TIME_BITS-1:0];
    assign pa_w    = DIV_W'(cfg.period_a);
    assign pb_w    = DIV_W'(cfg.period_b);

    // Map the raw mode code; codes past siren act as off.
    always_comb begin
        if (cfg.mode <= MODE_W'(MODE_SIREN)) begin
            mode = mode_t'(cfg.mode);
        end else begin
            mode = MODE_OFF;
        end
    end

    // Pick the cycle length that the time is reduced by.
    always_comb begin
        q_item.mode = mode;
        case (mode)
            MODE_BLINK: begin
                q_item.divisor = pa_w + pb_w;
            end
            MODE_FADE_IN, MODE_FADE_OUT, MODE_SHIFT: begin
                q_item.divisor = pa_w + DIV_W'(1);
            end
            MODE_BREATHE: begin
                q_item.divisor = pa_w + pb_w + DIV_W'(1);
            end
            MODE_RAINBOW, MODE_SIREN: begin
                q_item.divisor = pa_w;
            end
            default: begin
                q_item.divisor = DIV_W'(1);
            end
        endcase
    end

endmodule

// ----- rtl/lceg_back.sv -----
// Back part: pipelined time division, phase division, ease lookup and mixing.
module lceg_back #(
    parameter int TIME_BITS        = lceg_pkg::TIME_BITS_DEF,
    parameter int EASE_TABLE_DEPTH = lceg_pkg::EASE_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lceg_pkg::cfg_t           cfg,
    input  logic                     q_empty,
    input  lceg_pkg::item_t          q_item,
    input  logic [TIME_BITS-1:0]     q_time,
    output logic                     q_pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [lceg_pkg::LVL_W-1:0] m_red_level,
    output logic [lceg_pkg::LVL_W-1:0] m_green_level,
    output logic [lceg_pkg::LVL_W-1:0] m_blue_level
);
    import lceg_pkg::*;

    localparam int IDX_W = $clog2(EASE_TABLE_DEPTH + 1);
    localparam int PH_W  = PER_W + 1;
    localparam int PH_N  = PER_W + 1;

    logic en;

    // Time division stages.
    logic                  dv_valid_reg [TIME_BITS+1];
    mode_t                 dv_mode_reg  [TIME_BITS+1];
    logic [DIV_W-1:0]      dv_div_reg   [TIME_BITS+1];
    logic [TIME_BITS-1:0]  dv_t_reg     [TIME_BITS+1];
    logic [DIV_W-1:0]      dv_rem_reg   [TIME_BITS+1];
    logic [STAGE_W-1:0]    dv_q7_reg    [TIME_BITS+1];
    logic                  dv_qlsb_reg  [TIME_BITS+1];

    // Preparation stage.
    logic                  pp_valid_reg, pp_valid_next;
    logic [PH_W-1:0]       pp_num_reg, pp_num_next;
    logic [PER_W-1:0]      pp_per_reg, pp_per_next;
    side_t                 pp_side_reg, pp_side_next;

    // Phase division stages.
    logic                  ph_valid_reg [PH_N+1];
    logic [PH_W-1:0]       ph_r_reg     [PH_N+1];
    logic [PER_W-1:0]      ph_per_reg   [PH_N+1];
    logic [PH_W-1:0]       ph_q_reg     [PH_N+1];
    side_t                 ph_side_reg  [PH_N+1];

    // Index, ease and output stages.
    logic                  ix_valid_reg;
    logic [IDX_W-1:0]      ix_idx_reg, ix_idx_next;
    side_t                 ix_side_reg;
    logic                  ea_valid_reg;
    logic [EASE_W-1:0]     ea_e_reg, ea_e_next;
    side_t                 ea_side_reg;
    logic                  m_valid_reg;
    logic [LVL_W-1:0]      red_reg, red_next;
    logic [LVL_W-1:0]      green_reg, green_next;
    logic [LVL_W-1:0]      blue_reg, blue_next;

    logic [EASE_W-1:0]     ease_rom [EASE_TABLE_DEPTH+1];
    logic [PH_W+IDX_W-1:0] ix_prod;
    logic [COLOR_W-1:0]    mix_s, mix_t;
    logic [EASE_W-1:0]     mix_e;

    // The whole pipeline moves when the output register can take a result.
    assign en    = !m_valid_reg || m_ready;
    assign q_pop = en && !q_empty;

    // Division stage zero takes the queue head.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (en) begin
            dv_valid_reg[0] <= !q_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_mode_reg[0] <= q_item.mode;
            dv_div_reg[0]  <= q_item.divisor;
            dv_t_reg[0]    <= q_time;
            dv_rem_reg[0]  <= '0;
            dv_q7_reg[0]   <= '0;
            dv_qlsb_reg[0] <= 1'b0;
        end
    end

    // One restoring step per stage, most significant time bit first.
    // The quotient is kept only modulo seven and by its low bit.
    for (genvar i = 0; i < TIME_BITS; i++) begin : g_dv
        logic [DIV_W:0]     sh;
        logic [DIV_W:0]     diff;
        logic               ge;
        logic [STAGE_W:0]   q7x;
        logic [DIV_W-1:0]   rem_next;
        logic [STAGE_W-1:0] q7_next;

        always_comb begin
            sh       = {dv_rem_reg[i], dv_t_reg[i][TIME_BITS-1-i]};
            diff     = sh - {1'b0, dv_div_reg[i]};
            ge       = (sh >= {1'b0, dv_div_reg[i]});
            rem_next = ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
            q7x      = {dv_q7_reg[i], ge};
            q7_next  = (q7x >= (STAGE_W+1)'(7)) ? STAGE_W'(q7x - (STAGE_W+1)'(7))
                                                : q7x[STAGE_W-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[i+1] <= 1'b0;
            end else if (en) begin
                dv_valid_reg[i+1] <= dv_valid_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_mode_reg[i+1] <= dv_mode_reg[i];
                dv_div_reg[i+1]  <= dv_div_reg[i];
                dv_t_reg[i+1]    <= dv_t_reg[i];
                dv_rem_reg[i+1]  <= rem_next;
                dv_q7_reg[i+1]   <= q7_next;
                dv_qlsb_reg[i+1] <= ge;
            end
        end
    end

    // Choose the phase numerator and period, and the blink, invert and stage flags.
    always_comb begin
        pp_valid_next      = dv_valid_reg[TIME_BITS];
        pp_num_next        = dv_rem_reg[TIME_BITS];
        pp_per_next        = cfg.period_a;
        pp_side_next.mode  = dv_mode_reg[TIME_BITS];
        pp_side_next.inv   = (dv_mode_reg[TIME_BITS] == MODE_FADE_OUT);
        pp_side_next.on    = (dv_rem_reg[TIME_BITS] < DIV_W'(cfg.period_a));
        pp_side_next.stage = dv_q7_reg[TIME_BITS];
        if (dv_mode_reg[TIME_BITS] == MODE_SIREN) begin
            pp_side_next.stage = STAGE_W'(dv_qlsb_reg[TIME_BITS]);
        end
        // Blink needs no phase; a zero numerator keeps the table index in range.
        if (dv_mode_reg[TIME_BITS] == MODE_BLINK) begin
            pp_num_next = '0;
        end
        if (dv_mode_reg[TIME_BITS] == MODE_BREATHE &&
            dv_rem_reg[TIME_BITS] > DIV_W'(cfg.period_a)) begin
            pp_num_next      = dv_rem_reg[TIME_BITS] - DIV_W'(cfg.period_a);
            pp_per_next      = cfg.period_b;
            pp_side_next.inv = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pp_valid_reg <= 1'b0;
        end else if (en) begin
            pp_valid_reg <= pp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_num_reg  <= pp_num_next;
            pp_per_reg  <= pp_per_next;
            pp_side_reg <= pp_side_next;
        end
    end

    // Phase division stage zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_valid_reg[0] <= 1'b0;
        end else if (en) begin
            ph_valid_reg[0] <= pp_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ph_r_reg[0]    <= pp_num_reg;
            ph_per_reg[0]  <= pp_per_reg;
            ph_q_reg[0]    <= '0;
            ph_side_reg[0] <= pp_side_reg;
        end
    end

    // Phase quotient, one bit per stage: the integer bit first, then sixteen
    // fraction bits.
    for (genvar j = 0; j < PH_N; j++) begin : g_ph
        logic [PH_W-1:0] sh;
        logic            ge;
        logic [PH_W-1:0] r_next;

        always_comb begin
            if (j == 0) begin
                sh = ph_r_reg[j];
            end else begin
                sh = {ph_r_reg[j][PH_W-2:0], 1'b0};
            end
            ge     = (sh >= PH_W'(ph_per_reg[j]));
            r_next = ge ? (sh - PH_W'(ph_per_reg[j])) : sh;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ph_valid_reg[j+1] <= 1'b0;
            end else if (en) begin
                ph_valid_reg[j+1] <= ph_valid_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ph_r_reg[j+1]    <= r_next;
                ph_per_reg[j+1]  <= ph_per_reg[j];
                ph_q_reg[j+1]    <= {ph_q_reg[j][PH_W-2:0], ge};
                ph_side_reg[j+1] <= ph_side_reg[j];
            end
        end
    end

    // Scale the Q1.16 phase to a table index.
    always_comb begin
        ix_prod     = (PH_W+IDX_W)'(ph_q_reg[PH_N]) * (PH_W+IDX_W)'(EASE_TABLE_DEPTH);
        ix_idx_next = ix_prod[PER_W +: IDX_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ix_valid_reg <= 1'b0;
        end else if (en) begin
            ix_valid_reg <= ph_valid_reg[PH_N];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ix_idx_reg  <= ix_idx_next;
            ix_side_reg <= ph_side_reg[PH_N];
        end
    end

    // Ease table, filled with constants at elaboration. Each entry is
    // (1 - cos) / 2 in Q1.8 from a nine-term Taylor series in Q30; the upper
    // half mirrors the lower half.
    for (genvar k = 0; k <= EASE_TABLE_DEPTH; k++) begin : g_rom
        localparam bit          UPPER   = (2 * k > EASE_TABLE_DEPTH);
        localparam longint      KM      = UPPER ? (EASE_TABLE_DEPTH - k) : k;
        localparam logic [63:0] ANG     = (PI_Q30 * 64'(KM)) / 64'(EASE_TABLE_DEPTH);
        localparam logic [63:0] ANG2    = (ANG * ANG) >> 30;
        localparam logic [63:0] T1      = ((ONE_Q30 * ANG2) >> 30) / 64'd2;
        localparam logic [63:0] T2      = ((T1 * ANG2) >> 30) / 64'd12;
        localparam logic [63:0] T3      = ((T2 * ANG2) >> 30) / 64'd30;
        localparam logic [63:0] T4      = ((T3 * ANG2) >> 30) / 64'd56;
        localparam logic [63:0] T5      = ((T4 * ANG2) >> 30) / 64'd90;
        localparam logic [63:0] T6      = ((T5 * ANG2) >> 30) / 64'd132;
        localparam logic [63:0] T7      = ((T6 * ANG2) >> 30) / 64'd182;
        localparam logic [63:0] T8      = ((T7 * ANG2) >> 30) / 64'd240;
        localparam longint      SUM_RAW = longint'(ONE_Q30) - longint'(T1) + longint'(T2)
                                          - longint'(T3) + longint'(T4) - longint'(T5)
                                          + longint'(T6) - longint'(T7) + longint'(T8);
        localparam longint      SUM_LO  = (SUM_RAW < 0) ? 0 : SUM_RAW;
        localparam longint      SUM     = (SUM_LO > longint'(ONE_Q30)) ? longint'(ONE_Q30)
                                                                       : SUM_LO;
        localparam logic [63:0] E       = ((ONE_Q30 - 64'(SUM)) * 64'd128
                                          + (ONE_Q30 >> 1)) >> 30;
        assign ease_rom[k] = UPPER ? EASE_W'(64'd256 - E) : EASE_W'(E);
    end

    // Table lookup, reversed for the falling half of an effect.
    always_comb begin
        if (ix_side_reg.inv) begin
            ea_e_next = EASE_W'(256) - ease_rom[ix_idx_reg];
        end else begin
            ea_e_next = ease_rom[ix_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ea_valid_reg <= 1'b0;
        end else if (en) begin
            ea_valid_reg <= ix_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ea_e_reg    <= ea_e_next;
            ea_side_reg <= ix_side_reg;
        end
    end

    // Every effect is a blend of a start and an end color by the ease weight.
    always_comb begin
        mix_s = '0;
        mix_t = '0;
        mix_e = ea_e_reg;
        case (ea_side_reg.mode)
            MODE_SOLID: begin
                mix_s = cfg.color_a;
                mix_t = cfg.color_a;
            end
            MODE_BLINK: begin
                mix_s = ea_side_reg.on ? cfg.color_a : '0;
                mix_t = mix_s;
            end
            MODE_FADE_IN, MODE_FADE_OUT, MODE_BREATHE: begin
                mix_t = cfg.color_a;
            end
            MODE_SHIFT: begin
                mix_s = cfg.color_a;
                mix_t = cfg.color_b;
            end
            MODE_RAINBOW: begin
                mix_s = rainbow_color(ea_side_reg.stage);
                mix_t = rainbow_color((ea_side_reg.stage == STAGE_W'(6)) ? '0
                                      : ea_side_reg.stage + STAGE_W'(1));
            end
            MODE_SIREN: begin
                mix_s = ea_side_reg.stage[0] ? 24'h0000FF : 24'hFF0000;
                mix_t = ea_side_reg.stage[0] ? 24'hFF0000 : 24'h0000FF;
            end
            default: begin
                mix_e = '0;
            end
        endcase
    end

    // Weighted sum per channel; the result never exceeds 255.
    function automatic logic [LVL_W-1:0] blend(input logic [LVL_W-1:0] s,
                                               input logic [LVL_W-1:0] t,
                                               input logic [EASE_W-1:0] e);
        logic [PH_W:0] sum;
        sum = (PH_W+1)'(s) * (PH_W+1)'(EASE_W'(256) - e) + (PH_W+1)'(t) * (PH_W+1)'(e);
        return sum[LVL_W +: LVL_W];
    endfunction

    always_comb begin
        red_next   = blend(mix_s[23:16], mix_t[23:16], mix_e);
        green_next = blend(mix_s[15:8], mix_t[15:8], mix_e);
        blue_next  = blend(mix_s[7:0], mix_t[7:0], mix_e);
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= ea_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_red_level   = red_reg;
    assign m_green_level = green_reg;
    assign m_blue_level  = blue_reg;

endmodule

// ----- rtl/led_color_effect_generator.sv -----
// Top level of the LED color effect generator: registers, front, queue and back.
//
// Usage: each transfer on the s_ channel carries one millisecond time value;
// each transfer on the m_ channel returns the red, green and blue PWM levels
// for it, in order, one result per input. Effect, colors and periods are set
// through the write port (cfg_wr_en, cfg_addr, cfg_wdata); the user must set
// them only while no sample is in flight, as the block does not enforce this.
// A write to an unused index is dropped. A sample passes the queue, the
// division entry, one restoring division step per time bit, phase setup,
// phase division entry, seventeen steps for the Q1.16 phase, and the index,
// table and blend stages. Throughput is one sample per cycle while the
// output does not stall; the division stages are fully pipelined. When the
// receiver holds m_ready low with m_valid high, the whole pipeline holds,
// the two-entry queue takes up to two more samples, and then s_ready drops.
// Synchronous reset clears all valid flags and sets the registers to: mode off,
// both colors black, both periods 1000 ms.
module led_color_effect_generator #(
    parameter int TIME_BITS        = lceg_pkg::TIME_BITS_DEF,
    parameter int EASE_TABLE_DEPTH = lceg_pkg::EASE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [lceg_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [lceg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [31:0]                        s_time_ms,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [lceg_pkg::LVL_W-1:0]         m_red_level,
    output logic [lceg_pkg::LVL_W-1:0]         m_green_level,
    output logic [lceg_pkg::LVL_W-1:0]         m_blue_level
);
    import lceg_pkg::*;

    localparam int Q_W = $bits(item_t) + TIME_BITS;

    logic [MODE_W-1:0]  mode_reg;
    logic [COLOR_W-1:0] color_a_reg;
    logic [COLOR_W-1:0] color_b_reg;
    logic [PER_W-1:0]   period_a_reg;
    logic [PER_W-1:0]   period_b_reg;
    cfg_t               cfg;

    logic                 q_push, q_pop, q_full, q_empty;
    item_t                f_item, b_item;
    logic [TIME_BITS-1:0] f_time, b_time;
    logic [Q_W-1:0]       q_rdata;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_W'(MODE_OFF);
            color_a_reg  <= '0;
            color_b_reg  <= '0;
            period_a_reg <= PER_W'(1000);
            period_b_reg <= PER_W'(1000);
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_addr))
                REG_EFFECT_MODE: mode_reg     <= cfg_wdata[MODE_W-1:0];
                REG_COLOR_A:     color_a_reg  <= cfg_wdata[COLOR_W-1:0];
                REG_COLOR_B:     color_b_reg  <= cfg_wdata[COLOR_W-1:0];
                REG_PERIOD_A:    period_a_reg <= cfg_wdata[PER_W-1:0];
                REG_PERIOD_B:    period_b_reg <= cfg_wdata[PER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A zero period behaves as one millisecond.
    always_comb begin
        cfg.mode     = mode_reg;
        cfg.color_a  = color_a_reg;
        cfg.color_b  = color_b_reg;
        cfg.period_a = (period_a_reg == '0) ? PER_W'(1) : period_a_reg;
        cfg.period_b = (period_b_reg == '0) ? PER_W'(1) : period_b_reg;
    end

    lceg_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_time_ms (s_time_ms),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (f_item),
        .q_time    (f_time)
    );

    lceg_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   ({f_item, f_time}),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    assign b_item = item_t'(q_rdata[Q_W-1:TIME_BITS]);
    assign b_time = q_rdata[TIME_BITS-1:0];

    lceg_back #(
        .TIME_BITS        (TIME_BITS),
        .EASE_TABLE_DEPTH (EASE_TABLE_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .q_empty       (q_empty),
        .q_item        (b_item),
        .q_time        (b_time),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_level   (m_red_level),
        .m_green_level (m_green_level),
        .m_blue_level  (m_blue_level)
    );

endmodule
